>>> rtl/core/rcwc_pkg.sv
// shared types and constants of the raycast wall column setup block
package rcwc_pkg;

    localparam int TILE_SIZE_DEF     = 64;
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    localparam int DIR_W    = 16;
    localparam int COL_W    = 12;
    localparam int POS_W    = 24;
    localparam int DIST_W   = 24;
    localparam int TEXW_W   = 10;
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = 12;
    localparam int RGB_W    = 24;
    localparam int WIDTHS_W = 40;
    localparam int CFG_W    = 40;
    localparam int Q14      = 14;
    localparam int E_W      = 41;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_PLAYER_X   = 3'd0;
    localparam cfg_idx_t REG_PLAYER_Y   = 3'd1;
    localparam cfg_idx_t REG_TEX_WIDTHS = 3'd2;
    localparam cfg_idx_t REG_LOADED     = 3'd3;
    localparam cfg_idx_t REG_CEILING    = 3'd4;
    localparam cfg_idx_t REG_FLOOR      = 3'd5;

    typedef enum logic [1:0] {
        TEX_EAST,
        TEX_WEST,
        TEX_SOUTH,
        TEX_NORTH
    } tex_id_t;

    // sideband carried alongside the distance divider
    typedef struct packed {
        logic             side;
        tex_id_t          id;
        logic             mirror;
        logic             ezero;
        logic             czero;
        logic [DIR_W-1:0] other;
        logic [15:0]      oc;
        logic [COL_W-1:0] col;
    } dsb_t;

    // sideband carried alongside the height divider
    typedef struct packed {
        tex_id_t           id;
        logic [DIST_W-1:0] wall_dist;
        logic [TEXW_W-1:0] tex;
        logic [COL_W-1:0]  col;
    } hsb_t;

endpackage

>>> rtl/core/rcwc_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module rcwc_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quot,
    output logic [PW-1:0] out_side
);

    logic [NW-1:0] vld_reg;
    logic [NW-1:0] num_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [PW-1:0] side_reg [NW];

    genvar i;
    for (i = 0; i < NW; i++)
    begin : g_stage
        logic          v_prev;
        logic [NW-1:0] n_prev;
        logic [DW-1:0] r_prev;
        logic [DW-1:0] d_prev;
        logic [PW-1:0] s_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (i == 0)
        begin : g_first
            assign v_prev = in_valid;
            assign n_prev = in_num;
            assign r_prev = '0;
            assign d_prev = in_den;
            assign s_prev = in_side;
        end
        else
        begin : g_next
            assign v_prev = vld_reg[i-1];
            assign n_prev = num_reg[i-1];
            assign r_prev = rem_reg[i-1];
            assign d_prev = den_reg[i-1];
            assign s_prev = side_reg[i-1];
        end

        assign trial = {r_prev, n_prev[NW-1]};
        assign diff  = trial - {1'b0, d_prev};
        assign take  = (trial >= {1'b0, d_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i]  <= {n_prev[NW-2:0], take};
                rem_reg[i]  <= take ? diff[DW-1:0] : trial[DW-1:0];
                den_reg[i]  <= d_prev;
                side_reg[i] <= s_prev;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quot  = num_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

>>> rtl/core/raycast_wall_column_setup.sv
// raycast wall column setup: distance, texture column, wall rows and colours per column
// One screen column is taken every cycle unless the pipeline is stalled. NW1 is the quotient
// width of the ray distance divider (38 at the default sizes) and NW2 that of the wall height
// divider (24 at the defaults). Both dividers are bit-serial pipelines, one quotient bit per
// stage. A stall on the result side while a result is valid holds every stage at once; the
// item side is stalled for exactly those cycles. Configuration may be written only while no
// column is in flight.
module raycast_wall_column_setup
    import rcwc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_idx_t             cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 hit_side,
    input  logic                 step_x_positive,
    input  logic                 step_y_positive,
    input  logic [7:0]           tile_x,
    input  logic [7:0]           tile_y,
    input  logic [DIR_W-1:0]     dir_cos,
    input  logic [DIR_W-1:0]     dir_sin,
    input  logic [15:0]          offset_cos,
    input  logic [COL_W-1:0]     column,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [COL_W-1:0]     column_out,
    output logic [DIST_W-1:0]    distance,
    output logic [1:0]           texture_id,
    output logic [TEXW_W-1:0]    texture_column,
    output logic [HEIGHT_W-1:0]  wall_height,
    output logic [ROW_W-1:0]     start_row,
    output logic [ROW_W-1:0]     end_row,
    output logic                 params_valid,
    output logic [RGB_W-1:0]     ceiling_colour,
    output logic [RGB_W-1:0]     floor_colour
);

    localparam int TILE_SIZE = TILE_SIZE_DEF;
    localparam int MB     = $clog2(TILE_SIZE) + 8;
    localparam int BND_W  = 9 + MB;
    localparam int MAG_W  = (BND_W > POS_W) ? BND_W : POS_W;
    localparam int DLT_W  = MAG_W + 1;
    localparam int NW1    = MAG_W + Q14;
    localparam int HP_W   = Q14 + MB;
    localparam longint K  = longint'(TILE_SIZE) * longint'(SCREEN_WIDTH / 2) * 256;
    localparam int NW2    = $clog2(K + 1);
    localparam int SR_W   = 18;
    localparam int DSB_W  = $bits(dsb_t);
    localparam int HSB_W  = $bits(hsb_t);

    logic en;

    // configuration registers
    logic [POS_W-1:0]    player_x_reg;
    logic [POS_W-1:0]    player_y_reg;
    logic [WIDTHS_W-1:0] tex_widths_reg;
    logic [3:0]          loaded_reg;
    logic [RGB_W-1:0]    ceiling_reg;
    logic [RGB_W-1:0]    floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg   <= '0;
            player_y_reg   <= '0;
            tex_widths_reg <= '0;
            loaded_reg     <= '0;
            ceiling_reg    <= '0;
            floor_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLAYER_X:   player_x_reg   <= cfg_data[POS_W-1:0];
                REG_PLAYER_Y:   player_y_reg   <= cfg_data[POS_W-1:0];
                REG_TEX_WIDTHS: tex_widths_reg <= cfg_data[WIDTHS_W-1:0];
                REG_LOADED:     loaded_reg     <= cfg_data[3:0];
                REG_CEILING:    ceiling_reg    <= cfg_data[RGB_W-1:0];
                REG_FLOOR:      floor_reg      <= cfg_data[RGB_W-1:0];
                default:        ;
            endcase
        end
    end

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    // stage 1: boundary and signed delta
    logic [7:0]       tile_sel;
    logic [8:0]       tile_inc;
    logic [BND_W-1:0] bound;
    logic [POS_W-1:0] pos_sel;
    logic             stp;
    tex_id_t          id_next;

    logic             v1_reg;
    logic [DLT_W-1:0] delta1_reg;
    logic [DIR_W-1:0] c1_reg;
    logic [DIR_W-1:0] other1_reg;
    logic             side1_reg;
    tex_id_t          id1_reg;
    logic             mirror1_reg;
    logic [15:0]      oc1_reg;
    logic [COL_W-1:0] col1_reg;

    always_comb
    begin
        tile_sel = hit_side ? tile_y : tile_x;
        pos_sel  = hit_side ? player_y_reg : player_x_reg;
        stp      = hit_side ? step_y_positive : step_x_positive;
        tile_inc = {1'b0, tile_sel} + (stp ? 9'd0 : 9'd1);
        bound    = BND_W'(tile_inc) << MB;
        if (hit_side)
        begin
            id_next = stp ? TEX_SOUTH : TEX_NORTH;
        end
        else
        begin
            id_next = stp ? TEX_EAST : TEX_WEST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            delta1_reg  <= DLT_W'(bound) - DLT_W'(pos_sel);
            c1_reg      <= hit_side ? dir_sin : dir_cos;
            other1_reg  <= hit_side ? dir_cos : dir_sin;
            side1_reg   <= hit_side;
            id1_reg     <= id_next;
            mirror1_reg <= hit_side ? dir_sin[DIR_W-1]
                                    : (!dir_cos[DIR_W-1] && (dir_cos != '0));
            oc1_reg     <= offset_cos;
            col1_reg    <= column;
        end
    end

    // ray distance divider
    logic [DLT_W-1:0] delta_abs;
    logic [DIR_W-1:0] c_abs;
    logic [NW1-1:0]   num1;
    dsb_t             dsb_in;
    dsb_t             dsb_out;
    logic [DSB_W-1:0] dsb_out_w;
    logic             v1o;
    logic [NW1-1:0]   q1;

    always_comb
    begin
        delta_abs     = delta1_reg[DLT_W-1] ? (~delta1_reg + 1'b1) : delta1_reg;
        c_abs         = c1_reg[DIR_W-1] ? (~c1_reg + 1'b1) : c1_reg;
        num1          = {delta_abs[MAG_W-1:0], {Q14{1'b0}}};
        dsb_in.side   = side1_reg;
        dsb_in.id     = id1_reg;
        dsb_in.mirror = mirror1_reg;
        dsb_in.ezero  = delta1_reg[DLT_W-1] != c1_reg[DIR_W-1];
        dsb_in.czero  = c1_reg == '0;
        dsb_in.other  = other1_reg;
        dsb_in.oc     = oc1_reg;
        dsb_in.col    = col1_reg;
    end

    rcwc_div #(
        .NW (NW1),
        .DW (DIR_W),
        .PW (DSB_W)
    ) u_dist_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_num    (num1),
        .in_den    (c_abs),
        .in_side   (dsb_in),
        .out_valid (v1o),
        .out_quot  (q1),
        .out_side  (dsb_out_w)
    );

    assign dsb_out = dsb_t'(dsb_out_w);

    // stage a: clamped euclidean distance
    logic           va_reg;
    logic [E_W-1:0] ea_reg;
    dsb_t           sa_reg;

    // stage b: partial products
    logic             vb_reg;
    logic [39:0]      pl_reg;
    logic [32:0]      ph_reg;
    logic [HP_W-1:0]  hp_reg;
    dsb_t             sb_reg;

    // stage c: distance and position within the tile
    logic              vc_reg;
    logic [DIST_W-1:0] dist_c_reg;
    logic [MB-1:0]     m_c_reg;
    dsb_t              sc_reg;
    logic [56:0]       dsum;
    logic [41:0]       dshift;
    logic [POS_W-1:0]  pos_other;
    logic [MB-1:0]     m_next;

    // stage d: raw texel column
    logic               vd_reg;
    logic [TEXW_W-1:0]  texr_d_reg;
    logic [TEXW_W-1:0]  width_d_reg;
    logic [DIST_W-1:0]  dist_d_reg;
    dsb_t               sd_reg;
    logic [TEXW_W-1:0]  width_c;
    logic [MB+TEXW_W-1:0] tprod;

    always_comb
    begin
        dsum      = {ph_reg, 24'b0} + 57'(pl_reg);
        dshift    = dsum[56:15];
        pos_other = sb_reg.side ? player_x_reg : player_y_reg;
        m_next    = pos_other[MB-1:0] + hp_reg[HP_W-1:Q14];
        width_c   = tex_widths_reg[TEXW_W*int'(sc_reg.id) +: TEXW_W];
        tprod     = MB'(m_c_reg) * (MB+TEXW_W)'(width_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v1o;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dsb_out.czero)
            begin
                ea_reg <= {1'b1, {(E_W-1){1'b0}}};
            end
            else if (dsb_out.ezero)
            begin
                ea_reg <= '0;
            end
            else
            begin
                ea_reg <= E_W'(q1);
            end
            sa_reg <= dsb_out;

            pl_reg <= 40'(ea_reg[23:0]) * 40'(sa_reg.oc);
            ph_reg <= 33'(ea_reg[E_W-1:24]) * 33'(sa_reg.oc);
            hp_reg <= HP_W'({{(HP_W-DIR_W){sa_reg.other[DIR_W-1]}}, sa_reg.other}
                            * ea_reg[HP_W-1:0]);
            sb_reg <= sa_reg;

            dist_c_reg <= (dshift[41:DIST_W] != '0) ? {DIST_W{1'b1}} : dshift[DIST_W-1:0];
            m_c_reg    <= m_next;
            sc_reg     <= sb_reg;

            texr_d_reg  <= tprod[MB+TEXW_W-1:MB];
            width_d_reg <= width_c;
            dist_d_reg  <= dist_c_reg;
            sd_reg      <= sc_reg;
        end
    end

    // wall height divider
    hsb_t             hsb_in;
    hsb_t             hsb_out;
    logic [HSB_W-1:0] hsb_out_w;
    logic             v2o;
    logic [NW2-1:0]   q2;

    always_comb
    begin
        hsb_in.id        = sd_reg.id;
        hsb_in.wall_dist = dist_d_reg;
        hsb_in.col       = sd_reg.col;
        if (width_d_reg == '0)
        begin
            hsb_in.tex = '0;
        end
        else if (sd_reg.mirror)
        begin
            hsb_in.tex = width_d_reg - texr_d_reg - 1'b1;
        end
        else
        begin
            hsb_in.tex = texr_d_reg;
        end
    end

    rcwc_div #(
        .NW (NW2),
        .DW (DIST_W),
        .PW (HSB_W)
    ) u_height_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vd_reg),
        .in_num    (NW2'(K)),
        .in_den    (dist_d_reg),
        .in_side   (hsb_in),
        .out_valid (v2o),
        .out_quot  (q2),
        .out_side  (hsb_out_w)
    );

    assign hsb_out = hsb_t'(hsb_out_w);

    // stage e: saturated height and load check
    logic                ve_reg;
    logic [HEIGHT_W-1:0] height_e_reg;
    logic                pv_e_reg;
    hsb_t                se_reg;

    // output stage
    logic signed [SR_W-1:0] dh;
    logic signed [SR_W-1:0] s_row;
    logic signed [SR_W-1:0] e_row;
    logic [ROW_W-1:0]       start_next;
    logic [ROW_W-1:0]       end_next;

    logic                result_valid_reg;
    logic [COL_W-1:0]    column_reg;
    logic [DIST_W-1:0]   distance_reg;
    tex_id_t             tex_id_reg;
    logic [TEXW_W-1:0]   tex_col_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    start_reg;
    logic [ROW_W-1:0]    end_reg;
    logic                pv_reg;
    logic [RGB_W-1:0]    ceil_reg;
    logic [RGB_W-1:0]    flr_reg;

    always_comb
    begin
        dh    = SR_W'(SCREEN_HEIGHT) - SR_W'(height_e_reg);
        s_row = dh[SR_W-1] ? -((-dh) >>> 1) : (dh >>> 1);
        e_row = s_row + SR_W'(height_e_reg);
        start_next = s_row[SR_W-1] ? '0 : s_row[ROW_W-1:0];
        end_next   = (e_row >= SR_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                     : e_row[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg           <= v2o;
            result_valid_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            height_e_reg <= (q2[NW2-1:HEIGHT_W] != '0) ? {HEIGHT_W{1'b1}}
                                                       : q2[HEIGHT_W-1:0];
            pv_e_reg     <= loaded_reg[hsb_out.id];
            se_reg       <= hsb_out;

            column_reg   <= se_reg.col;
            distance_reg <= se_reg.wall_dist;
            tex_id_reg   <= se_reg.id;
            tex_col_reg  <= se_reg.tex;
            pv_reg       <= pv_e_reg;
            height_reg   <= pv_e_reg ? height_e_reg : '0;
            start_reg    <= pv_e_reg ? start_next : '0;
            end_reg      <= pv_e_reg ? end_next : '0;
            ceil_reg     <= pv_e_reg ? ceiling_reg : '0;
            flr_reg      <= pv_e_reg ? floor_reg : '0;
        end
    end

    assign result_valid   = result_valid_reg;
    assign column_out     = column_reg;
    assign distance       = distance_reg;
    assign texture_id     = tex_id_reg;
    assign texture_column = tex_col_reg;
    assign wall_height    = height_reg;
    assign start_row      = start_reg;
    assign end_row        = end_reg;
    assign params_valid   = pv_reg;
    assign ceiling_colour = ceil_reg;
    assign floor_colour   = flr_reg;

    a_unloaded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !params_valid |-> wall_height == '0 && ceiling_colour == '0
                                          && floor_colour == '0)
        else $error("unloaded texture beat carries wall data");

    a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && params_valid |-> end_row >= start_row
                                         && int'(end_row) < SCREEN_HEIGHT)
        else $error("wall rows out of order or off screen");

    a_entry_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> v1_reg)
        else $error("accepted beat lost at pipeline entry");

    a_hold_all: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(ve_reg) && $stable(va_reg))
        else $error("pipeline advanced under output stall");

endmodule

>>> tb/raycast_wall_column_setup_test.sv
// self-checking testbench for the raycast wall column setup block
`timescale 1ns / 1ps

typedef struct {
    logic [11:0] col;
    logic [23:0] wall_dist;
    logic [1:0]  id;
    logic [9:0]  tex;
    logic [15:0] height;
    logic [11:0] start;
    logic [11:0] stop;
    logic        valid;
    logic [23:0] ceil_c;
    logic [23:0] floor_c;
} column_params_t;

class column_scoreboard;
    column_params_t pending[$];
    int errors;
    logic [23:0] px, py, ceil_rgb, floor_rgb;
    logic [39:0] widths;
    logic [3:0]  loaded;

    function new();
        errors = 0;
        px = 0; py = 0; widths = 0; loaded = 0; ceil_rgb = 0; floor_rgb = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [39:0] val);
        case (idx)
            rcwc_pkg::REG_PLAYER_X:   px = val[23:0];
            rcwc_pkg::REG_PLAYER_Y:   py = val[23:0];
            rcwc_pkg::REG_TEX_WIDTHS: widths = val;
            rcwc_pkg::REG_LOADED:     loaded = val[3:0];
            rcwc_pkg::REG_CEILING:    ceil_rgb = val[23:0];
            rcwc_pkg::REG_FLOOR:      floor_rgb = val[23:0];
            default: ;
        endcase
    endfunction

    static function longint floor_q14(longint p);
        if (p >= 0)
            return p >>> 14;
        return -((-p + 16383) >>> 14);
    endfunction

    function void note_column(logic side, logic sxp, logic syp, logic [7:0] tx,
                              logic [7:0] ty, logic [15:0] dc_raw, logic [15:0] ds_raw,
                              logic [15:0] oc, logic [11:0] col);
        column_params_t r;
        longint tile_q8, bnd, delta, c, e, hit, m, tex, width, dc, ds, s, en;
        longint unsigned wall_dist, height;
        int id;
        tile_q8 = 64 * 256;
        dc = longint'($signed(dc_raw));
        ds = longint'($signed(ds_raw));
        if (!side)
        begin
            bnd = (tx + (sxp ? 0 : 1)) * tile_q8;
            delta = bnd - longint'(px);
            c = dc;
            id = sxp ? rcwc_pkg::TEX_EAST : rcwc_pkg::TEX_WEST;
        end
        else
        begin
            bnd = (ty + (syp ? 0 : 1)) * tile_q8;
            delta = bnd - longint'(py);
            c = ds;
            id = syp ? rcwc_pkg::TEX_SOUTH : rcwc_pkg::TEX_NORTH;
        end
        if (c == 0)
            e = 64'sd1 << 40;
        else
        begin
            e = (delta * 16384) / c;
            if (e < 0)
                e = 0;
            if (e > (64'sd1 << 40))
                e = 64'sd1 << 40;
        end
        wall_dist = (longint'(e) * longint'(oc)) >> 15;
        if (wall_dist > 24'hFFFFFF)
            wall_dist = 24'hFFFFFF;
        if (!side)
            hit = longint'(py) + floor_q14(ds * e);
        else
            hit = longint'(px) + floor_q14(dc * e);
        m = hit % tile_q8;
        if (m < 0)
            m += tile_q8;
        width = longint'((widths >> (10 * id)) & 40'h3FF);
        if (width == 0)
            tex = 0;
        else
        begin
            tex = (m * width) / tile_q8;
            if (tex >= width)
                tex = width - 1;
            if ((!side && dc > 0) || (side && ds < 0))
                tex = width - tex - 1;
        end
        r.col = col;
        r.wall_dist = wall_dist[23:0];
        r.id = id[1:0];
        r.tex = tex[9:0];
        r.valid = loaded[id];
        r.height = 0; r.start = 0; r.stop = 0; r.ceil_c = 0; r.floor_c = 0;
        if (r.valid)
        begin
            if (wall_dist == 0)
                height = 65535;
            else
            begin
                height = (64 * 512 * 256) / wall_dist;
                if (height > 65535)
                    height = 65535;
            end
            s = (768 - longint'(height)) / 2;
            en = s + longint'(height);
            if (s < 0)
                s = 0;
            if (en >= 768)
                en = 767;
            r.height = height[15:0];
            r.start = s[11:0];
            r.stop = en[11:0];
            r.ceil_c = ceil_rgb;
            r.floor_c = floor_rgb;
        end
        pending.push_back(r);
    endfunction

    function void check_column(column_params_t got);
        column_params_t x;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result, column %0d", $time, got.col);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (got.col !== x.col || got.wall_dist !== x.wall_dist || got.id !== x.id ||
            got.tex !== x.tex || got.height !== x.height || got.start !== x.start ||
            got.stop !== x.stop || got.valid !== x.valid || got.ceil_c !== x.ceil_c ||
            got.floor_c !== x.floor_c)
        begin
            $display("%0t: expected col=%0d dist=%h id=%0d tex=%0d h=%0d s=%0d e=%0d v=%b c=%h f=%h",
                     $time, x.col, x.wall_dist, x.id, x.tex, x.height, x.start, x.stop,
                     x.valid, x.ceil_c, x.floor_c);
            $display("%0t: actual   col=%0d dist=%h id=%0d tex=%0d h=%0d s=%0d e=%0d v=%b c=%h f=%h",
                     $time, got.col, got.wall_dist, got.id, got.tex, got.height, got.start,
                     got.stop, got.valid, got.ceil_c, got.floor_c);
            errors++;
        end
    endfunction
endclass

module raycast_wall_column_setup_test;
    import rcwc_pkg::*;

    localparam cfg_idx_t REG_SPARE = 3'd7;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    cfg_idx_t cfg_index = REG_PLAYER_X;
    logic [CFG_W-1:0] cfg_data = 0;
    logic item_valid = 0;
    logic item_stall;
    logic hit_side = 0, step_x_positive = 0, step_y_positive = 0;
    logic [7:0] tile_x = 0, tile_y = 0;
    logic [15:0] dir_cos = 0, dir_sin = 0, offset_cos = 0;
    logic [11:0] column = 0;
    logic result_valid;
    logic result_stall = 0;
    logic [11:0] column_out, start_row, end_row;
    logic [23:0] distance, ceiling_colour, floor_colour;
    logic [1:0] texture_id;
    logic [9:0] texture_column;
    logic [15:0] wall_height;
    logic params_valid;

    column_scoreboard board = new();
    int send_idle_pct = 0;
    int stall_pct = 0;

    raycast_wall_column_setup DUT (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        column_params_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.col = column_out; got.wall_dist = distance; got.id = texture_id;
            got.tex = texture_column; got.height = wall_height; got.start = start_row;
            got.stop = end_row; got.valid = params_valid; got.ceil_c = ceiling_colour;
            got.floor_c = floor_colour;
            board.check_column(got);
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    task automatic write_reg(cfg_idx_t idx, logic [39:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_column(logic side, logic sxp, logic syp, logic [7:0] tx,
                               logic [7:0] ty, logic [15:0] dc, logic [15:0] ds,
                               logic [15:0] oc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1; hit_side <= side; step_x_positive <= sxp;
        step_y_positive <= syp; tile_x <= tx; tile_y <= ty; dir_cos <= dc;
        dir_sin <= ds; offset_cos <= oc; column <= column + 12'd1;
        do @(posedge clk); while (item_stall);
        board.note_column(side, sxp, syp, tx, ty, dc, ds, oc, column);
        @(negedge clk);
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(4))
            0: return 16'($urandom_range(32768) - 16384);
            1: return 16'($urandom_range(16383, 8000));
            2: return 16'(-$urandom_range(16383, 8000));
            3: return 16'($urandom_range(40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_columns(int n);
        logic [7:0] tx, ty;
        repeat (n)
        begin
            tx = 8'(board.px[23:14]) + 8'($urandom_range(6) - 3);
            ty = 8'(board.py[23:14]) + 8'($urandom_range(6) - 3);
            if ($urandom_range(9) == 0)
            begin
                tx = 8'($urandom); ty = 8'($urandom);
            end
            send_column(1'($urandom), 1'($urandom), 1'($urandom), tx, ty, rand_dir(),
                        rand_dir(),
                        ($urandom_range(3) == 0) ? 16'($urandom) :
                        16'($urandom_range(32768, 20000)));
        end
    endtask

    task automatic random_config();
        write_reg(REG_PLAYER_X, $urandom_range(3) == 0 ? 40'($urandom) :
                  40'($urandom_range(16383 * 256, 256)));
        write_reg(REG_PLAYER_Y, $urandom_range(3) == 0 ? 40'($urandom) :
                  40'($urandom_range(16383 * 256, 256)));
        write_reg(REG_TEX_WIDTHS, {8'($urandom), 32'($urandom)});
        write_reg(REG_LOADED, 40'($urandom_range(15) | ($urandom_range(1) ? 4'hF : 4'h0)));
        write_reg(REG_CEILING, 40'($urandom));
        write_reg(REG_FLOOR, 40'($urandom));
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // default registers: nothing loaded, zero widths
        send_column(1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 16'sd16384, 16'sd0, 16'd32768);
        send_column(1'b1, 1'b0, 1'b1, 8'd255, 8'd255, 16'sd0, -16'sd16384, 16'd0);
        drain();
        write_reg(REG_PLAYER_X, 40'h20_0080);
        write_reg(REG_PLAYER_Y, 40'h1F_C040);
        write_reg(REG_TEX_WIDTHS, {10'd1023, 10'd64, 10'd1, 10'd0});
        write_reg(REG_LOADED, 40'hF);
        write_reg(REG_CEILING, 40'hFFFFFF);
        write_reg(REG_FLOOR, 40'h000000);
        write_reg(REG_SPARE, 40'hFF_FFFF_FFFF);
        send_column(1'b0, 1'b1, 1'b0, 8'd8, 8'd7, 16'sd16384, 16'sd0, 16'd32768);
        send_column(1'b0, 1'b0, 1'b1, 8'd7, 8'd8, -16'sd16384, 16'sd100, 16'd32768);
        send_column(1'b1, 1'b1, 1'b1, 8'd8, 8'd8, 16'sd5000, 16'sd11000, 16'd30000);
        send_column(1'b1, 1'b0, 1'b0, 8'd8, 8'd7, -16'sd5000, -16'sd11000, 16'd65535);
        send_column(1'b0, 1'b1, 1'b1, 8'd8, 8'd8, 16'sd0, 16'sd1, 16'd32768);
        send_column(1'b1, 1'b1, 1'b1, 8'd8, 8'd8, 16'sd1, 16'sd0, 16'd32768);
        send_column(1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 16'sd16384, 16'sd0, 16'd32768);
        send_column(1'b0, 1'b1, 1'b0, 8'd8, 8'd0, 16'sd1, 16'sd1, 16'd32768);
        send_column(1'b0, 1'b0, 1'b0, 8'd8, 8'd0, -16'sd1, 16'sd16384, 16'd1);
        send_column(1'b1, 1'b0, 1'b1, 8'd255, 8'd255, 16'h7FFF, 16'h8000, 16'd0);
        send_column(1'b1, 1'b1, 1'b0, 8'd255, 8'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
        drain();
        write_reg(REG_PLAYER_X, 40'hFF_FFFF);
        write_reg(REG_PLAYER_Y, 40'h0);
        write_reg(REG_LOADED, 40'h5);
        send_column(1'b0, 1'b0, 1'b1, 8'd255, 8'd0, 16'sd1, -16'sd3, 16'd32768);
        send_column(1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 16'sd3, 16'sd16384, 16'd32768);
        send_column(1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 16'sd3, -16'sd16384, 16'd32768);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            random_config();
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            random_columns(100);
            // let the pipeline empty mid-phase
            drain();
            random_columns(100);
            drain();
        end
        stall_pct = 0;
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
